@@ src/hfs_pkg.sv @@
package hfs_pkg;

    // Compatible words are scanned at offsets 16, 20, ... below this limit.
    localparam int SCAN_LIMIT = 64;
    localparam int OFFSET_SAT = SCAN_LIMIT + 3;
    localparam int OFF_W      = $clog2(OFFSET_SAT + 1);

    localparam logic [OFF_W-1:0] FTYP_END   = OFF_W'(7);
    localparam logic [OFF_W-1:0] MAJOR_END  = OFF_W'(11);
    localparam logic [OFF_W-1:0] COMPAT_END = OFF_W'(19);
    localparam logic [OFF_W-1:0] OFF_MAX    = OFF_W'(OFFSET_SAT);
    localparam logic [OFF_W-1:0] LAST_SHORT = OFF_W'(11);

    localparam logic [31:0] W_FTYP = 32'h6674_7970;
    localparam logic [31:0] W_HEIC = 32'h6865_6963;
    localparam logic [31:0] W_HEIX = 32'h6865_6978;
    localparam logic [31:0] W_HEVC = 32'h6865_7663;
    localparam logic [31:0] W_HEIM = 32'h6865_696D;
    localparam logic [31:0] W_HEIS = 32'h6865_6973;
    localparam logic [31:0] W_MIF1 = 32'h6D69_6631;
    localparam logic [31:0] W_MSF1 = 32'h6D73_6631;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic is_heif;
        logic ftyp_seen;
        logic major_brand_hit;
        logic compat_brand_hit;
        logic too_short;
    } t_out_item;

    function automatic logic is_compat_brand(input logic [31:0] w);
        return (w == W_HEIC) || (w == W_HEIX) || (w == W_HEVC);
    endfunction

    function automatic logic is_major_brand(input logic [31:0] w);
        return is_compat_brand(w) || (w == W_HEIM) || (w == W_HEIS) ||
               (w == W_MIF1) || (w == W_MSF1);
    endfunction

endpackage

@@ src/hfs_in_stage.sv @@
module hfs_in_stage
    import hfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_data
);

    logic     r_valid;
    t_in_item r_data;
    logic     w_load;

    // Register is free when empty or being drained this cycle.
    assign o_in_stall = r_valid && !i_take;
    assign w_load     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_in_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ src/hfs_scan.sv @@
module hfs_scan
    import hfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_data,
    output logic      o_take,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic [OFF_W-1:0] r_byte_offset, n_byte_offset;
    logic [23:0]      r_recent, n_recent;
    logic             r_ftyp, n_ftyp;
    logic             r_major, n_major;
    logic             r_compat_pending, n_compat_pending;
    logic             r_compat, n_compat;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        w_res;
    logic [31:0]      w_word;
    logic             w_out_free;
    logic             w_done;

    assign w_out_free = !r_out_valid || !i_out_stall;
    // A non-final byte never needs the result register.
    assign o_take     = i_valid && (!i_data.last_byte || w_out_free);
    assign w_done     = o_take && i_data.last_byte;
    assign w_word     = {r_recent, i_data.byte_value};

    always_comb begin
        n_ftyp           = r_ftyp;
        n_major          = r_major;
        n_compat         = r_compat || r_compat_pending;
        n_compat_pending = 1'b0;
        if (r_byte_offset == FTYP_END && w_word == W_FTYP) begin
            n_ftyp = 1'b1;
        end
        if (r_byte_offset == MAJOR_END && is_major_brand(w_word)) begin
            n_major = 1'b1;
        end
        if (r_byte_offset >= COMPAT_END && r_byte_offset < OFF_MAX &&
            r_byte_offset[1:0] == 2'b11 && is_compat_brand(w_word)) begin
            n_compat_pending = 1'b1;
        end
        n_recent      = w_word[23:0];
        n_byte_offset = (r_byte_offset < OFF_MAX) ? r_byte_offset + 1'b1
                                                   : r_byte_offset;

        w_res.too_short        = r_byte_offset < LAST_SHORT;
        w_res.ftyp_seen        = n_ftyp;
        w_res.major_brand_hit  = n_major;
        w_res.compat_brand_hit = n_compat;
        w_res.is_heif          = !w_res.too_short && n_ftyp && (n_major || n_compat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_done) begin
            r_byte_offset    <= '0;
            r_recent         <= '0;
            r_ftyp           <= 1'b0;
            r_major          <= 1'b0;
            r_compat_pending <= 1'b0;
            r_compat         <= 1'b0;
        end else if (o_take) begin
            r_byte_offset    <= n_byte_offset;
            r_recent         <= n_recent;
            r_ftyp           <= n_ftyp;
            r_major          <= n_major;
            r_compat_pending <= n_compat_pending;
            r_compat         <= n_compat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_heif_needs_sig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_heif |-> r_out.ftyp_seen && !r_out.too_short)
        else $error("is_heif without signature or with short file");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> r_byte_offset == '0 && !r_compat_pending && !r_ftyp)
        else $error("scan state not cleared after final byte");

    a_offset_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_offset <= OFF_MAX)
        else $error("offset counter past saturation");

    a_pending_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_compat_pending |-> r_byte_offset[1:0] == 2'b00 && r_byte_offset > COMPAT_END)
        else $error("compatible pending at wrong offset");

endmodule

@@ src/heif_ftyp_brand_sniffer_top.sv @@
// After the request carrying the final byte is accepted, its verdict passes through
// the input register, then the result register.
// Throughput: one byte per cycle; the scan state is updated once per byte in the
// single compare stage, and only the final byte waits on a stalled result.
// Reset (synchronous, active low) clears offset, history, flags and both valids.
module heif_ftyp_brand_sniffer_top
    import hfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // Registered byte handed to the compare stage.
    logic     w_stage_valid;
    t_in_item w_stage_data;
    logic     w_take;

    hfs_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_take     (w_take),
        .o_valid    (w_stage_valid),
        .o_data     (w_stage_data)
    );

    // Offset counter, 3-byte history, brand compares and the result register.
    hfs_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_stage_valid),
        .i_data      (w_stage_data),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/heif_ftyp_brand_sniffer_top_tb.sv @@
`timescale 1ns / 1ps

module heif_ftyp_brand_sniffer_top_tb;
    import hfs_pkg::*;

    // Header geometry used by the sniffer predictor, and the random stimulus size.
    localparam int HDR_MIN      = 12;
    localparam int COMPAT_FIRST = 16;
    localparam int RANDOM_BYTES = 1600;

    localparam logic [31:0] W_ISOM = 32'h6973_6F6D;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // One pending request plus a flag telling the driver to let all verdicts
    // drain before it offers this byte.
    typedef struct packed {
        t_in_item req;
        logic     drain;
    } t_stim;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    t_stim       header_q[$];
    logic [7:0]  file_buf[$];
    t_out_item   verdict_q[$];
    int unsigned sent_bytes = 0;
    int unsigned total_bytes = 0;
    int unsigned mismatches = 0;

    // Scan state of the predictor.
    logic [OFF_W-1:0] scan_off;
    logic [23:0]      scan_hist;
    logic             ftyp_hit;
    logic             major_hit;
    logic             compat_wait;
    logic             compat_hit;

    heif_ftyp_brand_sniffer_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic listed_compat(input logic [31:0] w);
        return w inside {W_HEIC, W_HEIX, W_HEVC};
    endfunction

    function automatic logic listed_major(input logic [31:0] w);
        return w inside {W_HEIC, W_HEIX, W_HEVC, W_HEIM, W_HEIS, W_MIF1, W_MSF1};
    endfunction

    task automatic clear_scan();
        scan_off    = '0;
        scan_hist   = '0;
        ftyp_hit    = 1'b0;
        major_hit   = 1'b0;
        compat_wait = 1'b0;
        compat_hit  = 1'b0;
    endtask

    // Advance the scan by one accepted byte; queue a verdict on the final byte.
    task automatic sniff_byte(input t_in_item req);
        logic [31:0]      word;
        logic [OFF_W-1:0] off;
        t_out_item        v;
        off  = scan_off;
        word = {scan_hist, req.byte_value};
        // any byte after a matched compatible word confirms it
        if (compat_wait) begin
            compat_hit  = 1'b1;
            compat_wait = 1'b0;
        end
        if (off == FTYP_END && word == W_FTYP)
            ftyp_hit = 1'b1;
        if (off == MAJOR_END && listed_major(word))
            major_hit = 1'b1;
        // word ends at offset 19, 23, ... and starts inside the scan window
        if (off >= COMPAT_FIRST + 3 && off < OFFSET_SAT && off[1:0] == 2'd3 &&
            (off - 3) < SCAN_LIMIT && listed_compat(word))
            compat_wait = 1'b1;
        scan_hist = word[23:0];
        if (off < OFFSET_SAT)
            scan_off = off + 1'b1;
        if (req.last_byte) begin
            v.too_short        = (int'(off) + 1) < HDR_MIN;
            v.ftyp_seen        = ftyp_hit;
            v.major_brand_hit  = major_hit;
            v.compat_brand_hit = compat_hit;
            v.is_heif          = !v.too_short && ftyp_hit && (major_hit || compat_hit);
            verdict_q.push_back(v);
            clear_scan();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic logic [31:0] brand_word(input int unsigned sel);
        case (sel)
            0:       return W_HEIC;
            1:       return W_HEIX;
            2:       return W_HEVC;
            3:       return W_HEIM;
            4:       return W_HEIS;
            5:       return W_MIF1;
            default: return W_MSF1;
        endcase
    endfunction

    // One byte of a brand flipped: close to a hit, though it can land on another listed brand.
    function automatic logic [31:0] near_miss();
        return brand_word($urandom_range(0, 6)) ^
               (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
    endfunction

    function automatic logic [31:0] compat_pick();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return brand_word($urandom_range(0, 2));
        else if (r < 6)
            return brand_word($urandom_range(3, 6));   // major-only brands
        else if (r < 8)
            return near_miss();
        return $urandom;
    endfunction

    task automatic put_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            file_buf.push_back(w[8*k +: 8]);
    endtask

    task automatic flush_file(input bit drain);
        t_stim s;
        for (int i = 0; i < file_buf.size(); i++) begin
            s.req.byte_value = file_buf[i];
            s.req.last_byte  = (i == file_buf.size() - 1);
            s.drain          = drain && (i == 0);
            header_q.push_back(s);
        end
        file_buf.delete();
    endtask

    // Mostly well-formed ftyp boxes with random brands, cut at random points
    // (often right at a word end); the rest is noise or has one signature or major brand byte damaged.
    task automatic random_file(input bit drain);
        int unsigned kind;
        int unsigned full;
        int unsigned cut;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 30))
                file_buf.push_back(8'($urandom));
        end else begin
            put_word($urandom);
            put_word(W_FTYP);
            put_word($urandom_range(0, 1) ? brand_word($urandom_range(0, 6)) : compat_pick());
            put_word($urandom);
            repeat ($urandom_range(0, 13))
                put_word(compat_pick());
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 80))
                    file_buf.push_back(8'($urandom));
            end else if ($urandom_range(0, 1) == 1) begin
                file_buf.push_back(8'($urandom));
            end
            if (kind == 1)
                file_buf[$urandom_range(4, 11)] ^= 8'($urandom_range(1, 255));
            full = file_buf.size();
            case ($urandom_range(0, 3))
                0:       cut = $urandom_range(1, full);
                1:       cut = 4 * $urandom_range(1, full / 4);
                default: cut = full;
            endcase
            while (file_buf.size() > cut)
                void'(file_buf.pop_back());
        end
        flush_file(drain);
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps between them.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk) begin : drive_proc
        t_stim nxt;
        logic  nv;
        nv = in_valid;
        if (!rst_n) begin
            nv         = 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (in_valid && !in_stall) begin
                sniff_byte(in_data);
                sent_bytes++;
                nv = 1'b0;
            end
            // a stalled request stays on the bus untouched
            if (!(in_valid && in_stall)) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (header_q.size() != 0 &&
                             (!header_q[0].drain || verdict_q.size() == 0)) begin
                    nxt     = header_q.pop_front();
                    in_data <= nxt.req;
                    nv      = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
        in_valid <= nv;
    end

    // ------------------------------------------------------------------
    // Result side stall: randomly chosen patterns, plus one long hold-off once the
    // run is under way so the block backs up into its input.
    // ------------------------------------------------------------------
    t_stall_mode stall_mode = STALL_NONE;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;

    always @(posedge clk) begin : stall_proc
        logic ns;
        ns = 1'b0;
        if (!rst_n) begin
            ns        = 1'b0;
            mode_left = 0;
        end else if (hold_left != 0) begin
            hold_left--;
            ns = 1'b1;
        end else if (!hold_done && sent_bytes >= 700) begin
            hold_done = 1'b1;
            hold_left = 300;
            ns        = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:  ns = 1'b0;
                STALL_LIGHT: ns = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: ns = ($urandom_range(0, 9) < 7);
                default:     ns = mode_left[1];
            endcase
        end
        out_stall <= ns;
    end

    // ------------------------------------------------------------------
    // Verdict monitor
    // ------------------------------------------------------------------
    task automatic check_bit(input string fname, input logic e, input logic a);
        if (a !== e) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, fname, e, a);
        end
    endtask

    always @(posedge clk) begin : watch_proc
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected verdict, expected none, actual %b", $time, out_data);
            end else begin
                want = verdict_q.pop_front();
                check_bit("is_heif", want.is_heif, out_data.is_heif);
                check_bit("ftyp_seen", want.ftyp_seen, out_data.ftyp_seen);
                check_bit("major_brand_hit", want.major_brand_hit, out_data.major_brand_hit);
                check_bit("compat_brand_hit", want.compat_brand_hit, out_data.compat_brand_hit);
                check_bit("too_short", want.too_short, out_data.too_short);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build all files, release reset, wait for the last verdict.
    // ------------------------------------------------------------------
    initial begin : main_seq
        int unsigned directed;
        int unsigned file_no;
        clear_scan();

        // lone 0xFF byte: shortest possible file
        file_buf.push_back(8'hFF);
        flush_file(1'b0);
        // 11 bytes with the signature: short, ftyp still reported
        put_word(32'h0000_0018);
        put_word(W_FTYP);
        put_word(W_MIF1);
        void'(file_buf.pop_back());
        flush_file(1'b0);
        // exactly 12 bytes, major brand hit
        put_word(32'hFFFF_FFFF);
        put_word(W_FTYP);
        put_word(W_HEIC);
        flush_file(1'b0);
        // compatible word on the final byte: left pending, not counted
        put_word(32'h0000_0014);
        put_word(W_FTYP);
        put_word(W_ISOM);
        put_word(32'h0);
        put_word(W_HEVC);
        flush_file(1'b0);
        // same with one trailing byte: compatible hit confirmed
        put_word(32'h0000_0018);
        put_word(W_FTYP);
        put_word(W_ISOM);
        put_word(32'h0);
        put_word(W_HEIX);
        file_buf.push_back(8'h00);
        flush_file(1'b0);
        // long file: brand just past the scan window must not count
        put_word(32'h0000_0050);
        put_word(W_FTYP);
        put_word(W_ISOM);
        repeat (13) put_word(32'h0);
        put_word(W_HEIC);
        repeat (12) file_buf.push_back(8'h00);
        flush_file(1'b0);

        directed = header_q.size();
        file_no  = 0;
        while (header_q.size() < directed + RANDOM_BYTES) begin
            random_file(file_no == 3 || $urandom_range(0, 9) == 0);
            file_no++;
        end
        total_bytes = header_q.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_bytes < total_bytes)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("[heif_ftyp_brand_sniffer_top] OK");
        else
            $display("[heif_ftyp_brand_sniffer_top] ERROR");
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("[heif_ftyp_brand_sniffer_top] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/hfs_pkg.sv
src/hfs_in_stage.sv
src/hfs_scan.sv
src/heif_ftyp_brand_sniffer_top.sv
tb/heif_ftyp_brand_sniffer_top_tb.sv
